FILE: sv/fupd_pkg.sv
// Shared types, codes and character helpers for the file URI percent decoder.
package fupd_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int CAP_BITS       = 16;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 16'd4096;

  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CAPACITY = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOWS  = 1'd1;

  localparam int PH_BITS = 3;
  localparam logic [PH_BITS-1:0] PH_PREFIX  = 3'd0;
  localparam logic [PH_BITS-1:0] PH_LEAD    = 3'd1;
  localparam logic [PH_BITS-1:0] PH_BODY    = 3'd2;
  localparam logic [PH_BITS-1:0] PH_ESC1    = 3'd3;
  localparam logic [PH_BITS-1:0] PH_ESC2    = 3'd4;
  localparam logic [PH_BITS-1:0] PH_DISCARD = 3'd5;

  localparam logic [1:0] ST_DATA     = 2'd0;
  localparam logic [1:0] ST_DONE     = 2'd1;
  localparam logic [1:0] ST_INVALID  = 2'd2;
  localparam logic [1:0] ST_CAPACITY = 2'd3;

  localparam logic [2:0] PREFIX_LEN = 3'd7;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_COLON   = 8'h3A;

  localparam int MAX_RES   = 3;
  localparam int FIFO_AW   = 2;
  localparam int FIFO_DEPTH = 1 << FIFO_AW;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_marker;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic [1:0]                  n;
    out_word_t [MAX_RES-1:0]     word;
  } push_t;

  function automatic logic [7:0] scheme_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h66;
      3'd1:    c = 8'h69;
      3'd2:    c = 8'h6C;
      3'd3:    c = 8'h65;
      3'd4:    c = 8'h3A;
      3'd5:    c = 8'h2F;
      3'd6:    c = 8'h2F;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

endpackage

FILE: sv/file_uri_percent_decoder.sv
// Top level of the file URI percent decoder: input register, config, decode, result queue.
// An accepted input word passes the input register, then the decoder writes its results into the result queue.
// Throughput: one input word per cycle while the result queue has room; an input word producing k results
//   puts k words into the result queue (k up to 3, at most at the drive-letter lead).
// Input is held off while the 4-entry result queue holds 2 or more words.
// Reset: out_capacity 4096, windows_mode 0, decoder at prefix start, queue empty.
module file_uri_percent_decoder import fupd_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  in_word_t                  in_word,
  output logic                      out_valid,
  input  logic                      out_stall,
  output out_word_t                 out_word,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CAP_BITS-1:0]       cfg_data
);

  in_word_t            item;
  logic                item_valid;
  logic                go;
  logic [CAP_BITS-1:0] out_capacity;
  logic                windows_mode;
  logic [FIFO_AW:0]    count;
  push_t               push;

  assign go       = item_valid && (count <= (FIFO_AW+1)'(FIFO_DEPTH - MAX_RES));
  assign in_stall = item_valid && !go;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      item_valid <= 1'b1;
    end else if (go) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) item <= in_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= CAP_RESET;
      windows_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CAPACITY: out_capacity <= cfg_data;
        CFG_WINDOWS:  windows_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  fupd_decode #(.COUNT_BITS(COUNT_BITS)) u_decode (
    .clk      (clk),
    .rst      (rst),
    .go       (go),
    .item     (item),
    .capacity (out_capacity),
    .windows  (windows_mode),
    .push     (push)
  );

  fupd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word),
    .count     (count)
  );

endmodule

FILE: sv/fupd_decode.sv
// Decoder state and single-pass next-state logic for one registered input word.
module fupd_decode import fupd_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  in_word_t            item,
  input  logic [CAP_BITS-1:0] capacity,
  input  logic                windows,
  output push_t               push
);

  localparam int CW = ((COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS) + 2;

  typedef struct packed {
    logic [PH_BITS-1:0]    phase;
    logic [3:0]            hn;
    logic [COUNT_BITS-1:0] cnt;
    logic                  put;
    out_word_t             word;
  } step_t;

  logic [PH_BITS-1:0]    phase, phase_next;
  logic [2:0]            prefix_pos, prefix_pos_next;
  logic [1:0]            held_count, held_count_next;
  logic [3:0]            high_nibble, high_nibble_next;
  logic [COUNT_BITS-1:0] out_count, out_count_next;
  logic [7:0]            held0, held0_next, held1, held1_next;
  push_t                 res;

  function automatic step_t fail_step(input step_t s_in, input logic [1:0] st);
    step_t s;
    s = s_in;
    s.put = 1'b1;
    s.word.out_byte = 8'h00;
    s.word.status = st;
    s.word.last = 1'b1;
    s.phase = PH_DISCARD;
    return s;
  endfunction

  function automatic step_t emit(input step_t s_in, input logic [7:0] b, input logic wm,
                                 input logic [CAP_BITS-1:0] cap);
    step_t s;
    logic [7:0] v;
    logic [CW-1:0] need;
    s = s_in;
    v = (wm && b == CH_SLASH) ? CH_BSLASH : b;
    need = {{(CW-COUNT_BITS){1'b0}}, s.cnt} + CW'(2);
    if (need > {{(CW-CAP_BITS){1'b0}}, cap}) begin
      s = fail_step(s, ST_CAPACITY);
    end else begin
      s.put = 1'b1;
      s.word.out_byte = v;
      s.word.status = ST_DATA;
      s.word.last = 1'b0;
      s.cnt = s.cnt + COUNT_BITS'(1);
    end
    return s;
  endfunction

  function automatic step_t feed(input step_t s_in, input logic [7:0] b, input logic wm,
                                 input logic [CAP_BITS-1:0] cap);
    step_t s;
    logic [4:0] h;
    s = s_in;
    s.put = 1'b0;
    s.word = '0;
    h = hex_digit(b);
    case (s.phase)
      PH_BODY: begin
        if (b == CH_PERCENT) s.phase = PH_ESC1;
        else s = emit(s, b, wm, cap);
      end
      PH_ESC1: begin
        if (!h[4]) begin
          s = fail_step(s, ST_INVALID);
        end else begin
          s.hn = h[3:0];
          s.phase = PH_ESC2;
        end
      end
      PH_ESC2: begin
        if (!h[4]) begin
          s = fail_step(s, ST_INVALID);
        end else begin
          s.phase = PH_BODY;
          s = emit(s, {s.hn, h[3:0]}, wm, cap);
        end
      end
      default: ;
    endcase
    return s;
  endfunction

  always_comb begin
    step_t      s;
    logic [1:0] n;
    logic [1:0] nh;
    logic [7:0] b;
    logic       fin;
    s.phase = phase;
    s.hn = high_nibble;
    s.cnt = out_count;
    s.put = 1'b0;
    s.word = '0;
    n = 2'd0;
    b = item.char_byte;
    fin = item.end_marker;
    res.word = '0;
    prefix_pos_next = prefix_pos;
    held_count_next = held_count;
    held0_next = held0;
    held1_next = held1;
    nh = (held_count > 2'd2) ? 2'd2 : held_count;
    case (phase)
      PH_PREFIX: begin
        if (capacity == '0 || fin || prefix_pos == PREFIX_LEN ||
            b != scheme_char(prefix_pos)) begin
          s = fail_step(s, ST_INVALID);
          res.word[n] = s.word; n = n + 2'd1;
        end else begin
          prefix_pos_next = prefix_pos + 3'd1;
          if (prefix_pos_next == PREFIX_LEN) begin
            s.phase = PH_LEAD;
            held_count_next = 2'd0;
          end
        end
      end
      PH_LEAD: begin
        if (fin) begin
          held_count_next = 2'd0;
          s.phase = PH_BODY;
          if (nh >= 2'd1) begin
            s = feed(s, held0, windows, capacity);
            if (s.put) begin res.word[n] = s.word; n = n + 2'd1; end
          end
          if (nh >= 2'd2) begin
            s = feed(s, held1, windows, capacity);
            if (s.put) begin res.word[n] = s.word; n = n + 2'd1; end
          end
          if (s.phase == PH_BODY) begin
            res.word[n].out_byte = 8'h00;
            res.word[n].status = ST_DONE;
            res.word[n].last = 1'b1;
            n = n + 2'd1;
          end
        end else if (held_count == 2'd0) begin
          if (windows && b == CH_SLASH) begin
            held0_next = b;
            held_count_next = 2'd1;
          end else begin
            s.phase = PH_BODY;
            s = feed(s, b, windows, capacity);
            if (s.put) begin res.word[n] = s.word; n = n + 2'd1; end
          end
        end else if (held_count == 2'd1) begin
          if (is_letter(b)) begin
            held1_next = b;
            held_count_next = 2'd2;
          end else begin
            held_count_next = 2'd0;
            s.phase = PH_BODY;
            s = feed(s, held0, windows, capacity);
            if (s.put) begin res.word[n] = s.word; n = n + 2'd1; end
            s = feed(s, b, windows, capacity);
            if (s.put) begin res.word[n] = s.word; n = n + 2'd1; end
          end
        end else begin
          held_count_next = 2'd0;
          s.phase = PH_BODY;
          if (b != CH_COLON) begin
            s = feed(s, held0, windows, capacity);
            if (s.put) begin res.word[n] = s.word; n = n + 2'd1; end
          end
          s = feed(s, held1, windows, capacity);
          if (s.put) begin res.word[n] = s.word; n = n + 2'd1; end
          s = feed(s, b, windows, capacity);
          if (s.put) begin res.word[n] = s.word; n = n + 2'd1; end
        end
      end
      PH_BODY: begin
        if (fin) begin
          res.word[n].out_byte = 8'h00;
          res.word[n].status = ST_DONE;
          res.word[n].last = 1'b1;
          n = n + 2'd1;
        end else begin
          s = feed(s, b, windows, capacity);
          if (s.put) begin res.word[n] = s.word; n = n + 2'd1; end
        end
      end
      PH_ESC1, PH_ESC2: begin
        if (fin) begin
          s = fail_step(s, ST_INVALID);
        end else begin
          s = feed(s, b, windows, capacity);
        end
        if (s.put) begin res.word[n] = s.word; n = n + 2'd1; end
      end
      default: ;
    endcase
    phase_next = s.phase;
    high_nibble_next = s.hn;
    out_count_next = s.cnt;
    if (fin) begin
      phase_next = PH_PREFIX;
      prefix_pos_next = 3'd0;
      held_count_next = 2'd0;
      high_nibble_next = 4'd0;
      out_count_next = '0;
    end
    res.n = go ? n : 2'd0;
  end

  assign push = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_PREFIX;
      prefix_pos <= 3'd0;
      held_count <= 2'd0;
      high_nibble <= 4'd0;
      out_count <= '0;
    end else if (go) begin
      phase <= phase_next;
      prefix_pos <= prefix_pos_next;
      held_count <= held_count_next;
      high_nibble <= high_nibble_next;
      out_count <= out_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      held0 <= held0_next;
      held1 <= held1_next;
    end
  end

  a_three_only_from_lead: assert property (@(posedge clk) disable iff (rst)
    go && push.n == 2'd3 |-> phase == PH_LEAD)
    else $error("three words from a phase other than lead");

  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    go && item.end_marker |=> phase == PH_PREFIX && out_count == '0 && held_count == 2'd0)
    else $error("end marker did not restart decoder");

  a_discard_silent: assert property (@(posedge clk) disable iff (rst)
    go && phase == PH_DISCARD && !item.end_marker |-> push.n == 2'd0)
    else $error("word produced while discarding");

endmodule

FILE: sv/fupd_fifo.sv
// Result queue: takes up to three words per cycle, delivers one per cycle unless out_stall holds it.
module fupd_fifo import fupd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  push_t            push,
  input  logic             out_stall,
  output logic             out_valid,
  output out_word_t        out_word,
  output logic [FIFO_AW:0] count
);

  out_word_t            mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wptr, rptr;
  logic                 pop;

  assign out_valid = (count != '0);
  assign out_word  = mem[rptr];
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (2'(k) < push.n) begin
        mem[wptr + FIFO_AW'(k)] <= push.word[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      wptr <= wptr + FIFO_AW'(push.n);
      if (pop) rptr <= rptr + FIFO_AW'(1);
      count <= count + (FIFO_AW+1)'(push.n) - (FIFO_AW+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.n != 2'd0 |-> count + (FIFO_AW+1)'(push.n) <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("queue count out of range");

  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    FIFO_AW'(wptr - rptr) == count[FIFO_AW-1:0])
    else $error("queue pointers disagree with count");

endmodule
